/* rtl/scspr_pkg.sv */
// shared constants, types and state codes of the second-chance page replacer
package scspr_pkg;

  // sizes of the page and frame tables
  localparam int PAGE_W     = 6;
  localparam int FRAME_W    = 5;
  localparam int NUM_PAGES  = 1 << PAGE_W;
  localparam int NUM_FRAMES = 1 << FRAME_W;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int CFG_W      = 7;
  localparam int SRC_W      = 2;

  // fill source codes
  localparam logic [SRC_W-1:0] SRC_RESIDENT = 2'd0;
  localparam logic [SRC_W-1:0] SRC_EXEC     = 2'd1;
  localparam logic [SRC_W-1:0] SRC_SWAP     = 2'd2;
  localparam logic [SRC_W-1:0] SRC_ZERO     = 2'd3;

  // one page table word
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               use_bit;
    logic               dirty;
    logic               in_swap;
  } pte_t;

  localparam int PTE_W = $bits(pte_t);

  // one result, as handed from the core to the output register
  typedef struct packed {
    logic               write_back;
    logic [PAGE_W-1:0]  victim_page;
    logic               evicted;
    logic [SRC_W-1:0]   fill_source;
    logic [FRAME_W-1:0] frame;
    logic               hit;
  } res_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_SWO   = 6'b000100,
    ST_SWP   = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

/* rtl/scspr_ram.sv */
// generic single write port ram with one registered read port
module scspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/scspr_core.sv */
// table sequencer: page lookup, free frame allocation and clock sweep
module scspr_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [scspr_pkg::CFG_W-1:0]       first_blank_page,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [scspr_pkg::PAGE_W-1:0]      req_page,
  input  logic                              req_write,
  output logic                              res_valid,
  input  logic                              res_ready,
  output scspr_pkg::res_t                   res
);

  localparam int PW = scspr_pkg::PAGE_W;
  localparam int FW = scspr_pkg::FRAME_W;

  scspr_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]                 page_r;
  logic                          wr_r;
  logic                          swap_r, swap_nxt;
  logic [FW-1:0]                 hand_r, hand_nxt, hand_inc;
  logic [scspr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [scspr_pkg::NUM_PAGES-1:0] valid_r, valid_nxt;
  logic [scspr_pkg::NUM_PAGES-1:0] written_r, written_nxt;
  scspr_pkg::res_t               res_r, res_nxt;

  // page table ram signals
  logic                          pt_we;
  logic [PW-1:0]                 pt_waddr;
  scspr_pkg::pte_t               pt_wdata;
  logic [PW-1:0]                 pt_raddr, pt_raddr_r;
  logic [scspr_pkg::PTE_W-1:0]   pt_rdata;
  scspr_pkg::pte_t               pte;

  // frame owner ram signals
  logic                          fo_we;
  logic [FW-1:0]                 fo_waddr;
  logic [PW-1:0]                 fo_wdata;
  logic [PW-1:0]                 fo_rdata;

  scspr_ram #(.WIDTH(scspr_pkg::PTE_W), .DEPTH(scspr_pkg::NUM_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  scspr_ram #(.WIDTH(PW), .DEPTH(scspr_pkg::NUM_FRAMES)) u_owner_ram (
    .clk   (clk),
    .we    (fo_we),
    .waddr (fo_waddr),
    .wdata (fo_wdata),
    .raddr (hand_nxt),
    .rdata (fo_rdata)
  );

  // entries never written read as zero
  assign pte = written_r[pt_raddr_r] ? scspr_pkg::pte_t'(pt_rdata) : '0;

  // page ram read address: owner during the sweep, else the incoming page
  assign pt_raddr = (state_r == scspr_pkg::ST_SWO) ? fo_rdata : req_page;

  assign hand_inc = (hand_r == FW'(scspr_pkg::NUM_FRAMES - 1)) ? '0 : hand_r + 1'b1;

  assign req_ready = (state_r == scspr_pkg::ST_IDLE);
  assign res_valid = (state_r == scspr_pkg::ST_OUT);
  assign res       = res_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    swap_nxt    = swap_r;
    hand_nxt    = hand_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    written_nxt = written_r;
    res_nxt     = res_r;
    pt_we       = 1'b0;
    pt_waddr    = page_r;
    pt_wdata    = '0;
    fo_we       = 1'b0;
    fo_waddr    = res_r.frame;
    fo_wdata    = page_r;
    case (state_r)
      scspr_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_nxt = scspr_pkg::ST_LOOK;
        end
      end
      scspr_pkg::ST_LOOK: begin
        res_nxt = '0;
        if (valid_r[page_r]) begin
          // hit: mark used, and dirty on a write
          pt_we               = 1'b1;
          pt_wdata            = pte;
          pt_wdata.use_bit    = 1'b1;
          pt_wdata.dirty      = pte.dirty | wr_r;
          res_nxt.hit         = 1'b1;
          res_nxt.frame       = pte.frame;
          res_nxt.fill_source = scspr_pkg::SRC_RESIDENT;
          state_nxt           = scspr_pkg::ST_OUT;
        end else begin
          swap_nxt = pte.in_swap;
          if (cnt_r < scspr_pkg::CNT_W'(scspr_pkg::NUM_FRAMES)) begin
            // frames are never freed, so the lowest free one is the fill count
            res_nxt.frame = cnt_r[FW-1:0];
            cnt_nxt       = cnt_r + 1'b1;
            state_nxt     = scspr_pkg::ST_FILL;
          end else begin
            state_nxt = scspr_pkg::ST_SWO;
          end
        end
      end
      scspr_pkg::ST_SWO: begin
        // page table entry of the owner of the frame under the hand is now read from the page ram
        state_nxt = scspr_pkg::ST_SWP;
      end
      scspr_pkg::ST_SWP: begin
        pt_we    = 1'b1;
        pt_waddr = pt_raddr_r;
        pt_wdata = pte;
        pt_wdata.use_bit = 1'b0;
        hand_nxt = hand_inc;
        if (pte.use_bit) begin
          // second chance: clear use and move on
          state_nxt = scspr_pkg::ST_SWO;
        end else begin
          // victim found
          pt_wdata.dirty          = 1'b0;
          pt_wdata.in_swap        = pte.in_swap | pte.dirty;
          valid_nxt[pt_raddr_r]   = 1'b0;
          res_nxt.frame           = hand_r;
          res_nxt.evicted         = 1'b1;
          res_nxt.victim_page     = pt_raddr_r;
          res_nxt.write_back      = pte.dirty;
          state_nxt               = scspr_pkg::ST_FILL;
        end
      end
      scspr_pkg::ST_FILL: begin
        // install the new page and record its frame owner
        pt_we            = 1'b1;
        pt_waddr         = page_r;
        pt_wdata.frame   = res_r.frame;
        pt_wdata.use_bit = 1'b1;
        pt_wdata.dirty   = wr_r;
        pt_wdata.in_swap = 1'b0;
        valid_nxt[page_r]   = 1'b1;
        written_nxt[page_r] = 1'b1;
        fo_we = 1'b1;
        if (swap_r) begin
          res_nxt.fill_source = scspr_pkg::SRC_SWAP;
        end else if ({1'b0, page_r} < first_blank_page) begin
          res_nxt.fill_source = scspr_pkg::SRC_EXEC;
        end else begin
          res_nxt.fill_source = scspr_pkg::SRC_ZERO;
        end
        state_nxt = scspr_pkg::ST_OUT;
      end
      scspr_pkg::ST_OUT: begin
        if (res_ready) begin
          state_nxt = scspr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scspr_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scspr_pkg::ST_IDLE;
      hand_r    <= '0;
      cnt_r     <= '0;
      valid_r   <= '0;
      written_r <= '0;
    end else begin
      state_r   <= state_nxt;
      hand_r    <= hand_nxt;
      cnt_r     <= cnt_nxt;
      valid_r   <= valid_nxt;
      written_r <= written_nxt;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      page_r <= req_page;
      wr_r   <= req_write;
    end
    pt_raddr_r <= pt_raddr;
    swap_r     <= swap_nxt;
    res_r      <= res_nxt;
  end

endmodule

/* rtl/second_chance_page_replacer_unit.sv */
// top level of the second-chance page replacer: ports, config register, output register
//
// Usage:
//   in_*  : one request per page access; in_tdata[5:0] page, [6] is_write.
//   out_* : one result per request, in request order (see out_tdata fields).
//   cfg_* : writes first_blank_page; only while no request is in flight.
// Flow:
//   A request is taken only while the sequencer is idle, so a new request
//   is not taken until the previous result has left the sequencer. A hit
//   goes from the lookup state to the result state; a miss with a free
//   frame passes through the fill state between them. A miss with all
//   frames taken runs the clock sweep: the owner ram read followed by the
//   page ram read for each frame, with at most 32 use bits cleared.
// Reset (rst_n low, synchronous): all pages non-resident, no frames taken,
//   clock hand and first_blank_page zero, output register empty.
// Stall: the output register holds its result while out_tready is low;
//   the next request may be accepted, but its result waits until the
//   output register is free.
module second_chance_page_replacer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request: [5:0] page, [6] is_write, [7] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // result: [0] hit, [5:1] frame, [7:6] fill_source, [8] evicted,
  //         [14:9] victim_page, [15] write_back
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // configuration: [6:0] first_blank_page
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic [scspr_pkg::CFG_W-1:0] fbp_r;
  logic                        out_valid_r;
  scspr_pkg::res_t             out_r;
  logic                        res_valid;
  logic                        res_ready;
  scspr_pkg::res_t             res;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbp_r <= '0;
    end else if (cfg_valid) begin
      fbp_r <= cfg_data;
    end
  end

  scspr_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .first_blank_page (fbp_r),
    .req_valid        (in_tvalid),
    .req_ready        (in_tready),
    .req_page         (in_tdata[scspr_pkg::PAGE_W-1:0]),
    .req_write        (in_tdata[scspr_pkg::PAGE_W]),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

/* sim/tb_second_chance_page_replacer_unit.sv */
// self-checking testbench of the second-chance page replacer, with a scoreboard class
module tb_second_chance_page_replacer_unit;

  localparam int HALF_PERIOD     = 5;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CFG_SETTLE      = 10;
  localparam int END_SETTLE      = 150;
  localparam int PHASE_ITEMS     = 170;
  localparam int NUM_PHASES      = 7;

  // page table mirror and queue of awaited results
  class replacer_scoreboard;
    bit                            resident[scspr_pkg::NUM_PAGES];
    logic [scspr_pkg::FRAME_W-1:0] page_frame[scspr_pkg::NUM_PAGES];
    bit                            referenced[scspr_pkg::NUM_PAGES];
    bit                            modified[scspr_pkg::NUM_PAGES];
    bit                            swapped[scspr_pkg::NUM_PAGES];
    logic [scspr_pkg::PAGE_W-1:0]  owner[scspr_pkg::NUM_FRAMES];
    bit                            taken[scspr_pkg::NUM_FRAMES];
    logic [scspr_pkg::FRAME_W-1:0] hand = '0;
    logic [scspr_pkg::CFG_W-1:0]   exec_limit;
    scspr_pkg::res_t               awaited[$];
    int                            errors;

    function void set_exec_limit(logic [scspr_pkg::CFG_W-1:0] value);
      exec_limit = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // work out the result of one page access and update the tables
    function void note_access(logic [scspr_pkg::PAGE_W-1:0] page, logic wr);
      scspr_pkg::res_t              r;
      bit                           found;
      logic [scspr_pkg::PAGE_W-1:0] victim;
      r = '0;
      if (resident[page]) begin
        r.hit         = 1'b1;
        r.frame       = page_frame[page];
        r.fill_source = scspr_pkg::SRC_RESIDENT;
      end else begin
        found = 1'b0;
        for (int f = 0; f < scspr_pkg::NUM_FRAMES; f++) begin
          if (!found && !taken[f]) begin
            found   = 1'b1;
            r.frame = scspr_pkg::FRAME_W'(f);
          end
        end
        // no free frame: sweep, clearing use bits, until an unused owner turns up
        if (!found) begin
          for (int n = 0; n < 2 * scspr_pkg::NUM_FRAMES && referenced[owner[hand]]; n++) begin
            referenced[owner[hand]] = 1'b0;
            hand = hand + 1'b1;
          end
          r.frame       = hand;
          hand          = hand + 1'b1;
          victim        = owner[r.frame];
          r.evicted     = 1'b1;
          r.victim_page = victim;
          if (modified[victim]) begin
            r.write_back     = 1'b1;
            swapped[victim]  = 1'b1;
            modified[victim] = 1'b0;
          end
          resident[victim] = 1'b0;
        end
        // swap copy wins over the executable image
        if (swapped[page])
          r.fill_source = scspr_pkg::SRC_SWAP;
        else if ({1'b0, page} < exec_limit)
          r.fill_source = scspr_pkg::SRC_EXEC;
        else
          r.fill_source = scspr_pkg::SRC_ZERO;
        swapped[page]    = 1'b0;
        resident[page]   = 1'b1;
        page_frame[page] = r.frame;
        owner[r.frame]   = page;
        taken[r.frame]   = 1'b1;
      end
      referenced[page] = 1'b1;
      if (wr)
        modified[page] = 1'b1;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, seen);
      end
    endfunction

    // compare one result with the oldest awaited one
    function void check_result(logic [15:0] data);
      scspr_pkg::res_t seen;
      scspr_pkg::res_t want;
      seen = scspr_pkg::res_t'(data);
      if (awaited.size() == 0) begin
        errors++;
        $error("result %h with no request outstanding", data);
        return;
      end
      want = awaited.pop_front();
      compare_field("hit", int'(want.hit), int'(seen.hit));
      compare_field("frame", int'(want.frame), int'(seen.frame));
      compare_field("fill_source", int'(want.fill_source), int'(seen.fill_source));
      compare_field("evicted", int'(want.evicted), int'(seen.evicted));
      compare_field("victim_page", int'(want.victim_page), int'(seen.victim_page));
      compare_field("write_back", int'(want.write_back), int'(seen.write_back));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  replacer_scoreboard sb = new;
  bit idling_on        = 1'b1;
  bit hold_off_pending = 1'b0;
  int quiet_cycles     = 0;

  second_chance_page_replacer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // watchdog on cycles without any accepted request, result or write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result receiver: random stall bursts and one long hold-off
  initial begin
    int stall_len;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_len = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one page access, with an occasional gap before it
  task automatic send_access(input logic [scspr_pkg::PAGE_W-1:0] page, input logic wr);
    int gap;
    gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, wr, page};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_access(page, wr);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained(input int settle);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_first_blank(input logic [scspr_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_exec_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a drifting working set of 20 to 48 pages, around the size of the frame pool
  task automatic run_random_phase(input int count);
    logic [scspr_pkg::PAGE_W-1:0] base;
    logic [scspr_pkg::PAGE_W-1:0] page;
    int                           span;
    base = scspr_pkg::PAGE_W'($urandom);
    span = $urandom_range(20, 48);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        page = scspr_pkg::PAGE_W'(base + $urandom_range(0, span - 1));
      else
        page = scspr_pkg::PAGE_W'($urandom);
      send_access(page, $urandom_range(0, 9) < 4);
      if ($urandom_range(0, 63) == 0) begin
        base = scspr_pkg::PAGE_W'($urandom);
        span = $urandom_range(20, 48);
      end
    end
    stop_requests();
  endtask

  initial begin
    logic [scspr_pkg::CFG_W-1:0] phase_limit[NUM_PHASES];
    phase_limit = '{7'd0, 7'd32, 7'd64, 7'd0, 7'd1, 7'd63, 7'd0};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme and alternating page numbers, reads and writes, hits
    write_first_blank(7'd64);
    send_access(6'd0, 1'b0);
    send_access(6'd63, 1'b1);
    send_access(6'd0, 1'b1);
    send_access(6'd63, 1'b0);
    send_access(6'd21, 1'b1);
    send_access(6'd42, 1'b0);
    send_access(6'd21, 1'b0);
    send_access(6'd42, 1'b1);
    send_access(6'd0, 1'b0);
    stop_requests();
    wait_drained(CFG_SETTLE);

    // random phases, each under its own first blank page
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3)
        phase_limit[p] = scspr_pkg::CFG_W'($urandom_range(0, 64));
      if (p == NUM_PHASES - 1)
        idling_on = 1'b0;
      write_first_blank(phase_limit[p]);
      if (p == 2)
        hold_off_pending = 1'b1;
      run_random_phase(PHASE_ITEMS);
      wait_drained(CFG_SETTLE);
    end

    wait_drained(END_SETTLE);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
